### rtl/core/spimbo_pkg.sv
`timescale 1ns / 1ps

package spimbo_pkg;

    // Word length of one serial transfer.
    localparam int BITS_PER_WORD = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD + 1);

    typedef logic [BITS_PER_WORD-1:0] t_word;
    typedef logic [BIT_IDX_W-1:0]     t_bit_idx;

    // Command codes on the action field.
    localparam logic [2:0] ACTION_TICK  = 3'd0;
    localparam logic [2:0] ACTION_BEGIN = 3'd1;
    localparam logic [2:0] ACTION_XFER  = 3'd2;
    localparam logic [2:0] ACTION_END   = 3'd3;
    localparam logic [2:0] ACTION_DUMMY = 3'd4;

    // Activity state codes.
    localparam logic [1:0] ACT_IDLE  = 2'd0;
    localparam logic [1:0] ACT_XFER  = 2'd1;
    localparam logic [1:0] ACT_DUMMY = 2'd2;

    // Register indexes on the APB port.
    localparam logic [1:0] REG_SPI_MODE  = 2'd0;
    localparam logic [1:0] REG_LSB_FIRST = 2'd1;
    localparam logic [1:0] REG_HALF_DLY  = 2'd2;

    localparam int    ADDR_W    = 4;
    localparam t_word WORD_ONES = '1;

    // Bit reversal of one word.
    function automatic t_word flip_word(input t_word v);
        t_word r;
        for (int i = 0; i < BITS_PER_WORD; i++) begin
            r[i] = v[BITS_PER_WORD-1-i];
        end
        return r;
    endfunction

endpackage

### rtl/core/spi_master_mode_bitorder_unit.sv
`timescale 1ns / 1ps

// SPI master with selectable CPOL/CPHA mode and bit order. Every input beat is
// one tick of the serial clock generator: it carries a command (tick only,
// begin, transfer word, end, dummy clocks) plus the sampled MISO level, and
// yields exactly one result beat holding the line levels (sclk, mosi, cs_n)
// after that tick, the received word with rx_valid on the completing tick, and
// busy. A clock half lasts half_period_delay+1 ticks, so a word takes
// 2*BITS_PER_WORD*(half_period_delay+1) beats. Commands other than tick are
// ignored while busy; busy already drops on the completing tick. Throughput is
// one beat per clock: the tick logic sits between the state registers and a
// single output register, and a new beat is taken whenever that register is
// empty or being drained, so the result appears in the cycle after acceptance.
// Configuration (APB, registers at 0x0 mode, 0x4 lsb_first, 0x8 delay) must be
// written only while the block is idle; pready is tied high.
module spi_master_mode_bitorder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [spimbo_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_tx_byte,
    input  logic [7:0]  i_dummy_count,
    input  logic        i_miso,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_sclk,
    output logic        o_mosi,
    output logic        o_cs_n,
    output logic [7:0]  o_rx_byte,
    output logic        o_rx_valid,
    output logic        o_busy_res
);

    // configuration registers
    logic [1:0] r_spi_mode;
    logic       r_lsb_first;
    logic [7:0] r_half_dly;

    // engine state
    logic [1:0]             r_activity;
    spimbo_pkg::t_word      r_tx_shift;
    spimbo_pkg::t_word      r_rx_shift;
    spimbo_pkg::t_bit_idx   r_bit_index;
    logic                   r_edge_half;
    logic [7:0]             r_delay_count;
    logic                   r_clock_level;
    logic                   r_mosi_level;
    logic                   r_select_active;
    logic [7:0]             r_dummy_left;

    // next state
    logic [1:0]             n_activity;
    spimbo_pkg::t_word      n_tx_shift;
    spimbo_pkg::t_word      n_rx_shift;
    spimbo_pkg::t_bit_idx   n_bit_index;
    logic                   n_edge_half;
    logic [7:0]             n_delay_count;
    logic                   n_clock_level;
    logic                   n_mosi_level;
    logic                   n_select_active;
    logic [7:0]             n_dummy_left;
    logic [7:0]             n_rx_out;
    logic                   n_rx_valid;

    // output register
    logic       r_out_valid;
    logic       r_sclk;
    logic       r_mosi;
    logic       r_cs_n;
    logic [7:0] r_rx_byte;
    logic       r_rx_valid;
    logic       r_busy;

    logic w_in_acc;
    logic w_cfg_wr;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_mode  <= 2'd0;
            r_lsb_first <= 1'b0;
            r_half_dly  <= 8'd0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                spimbo_pkg::REG_SPI_MODE:  r_spi_mode  <= pwdata[1:0];
                spimbo_pkg::REG_LSB_FIRST: r_lsb_first <= pwdata[0];
                spimbo_pkg::REG_HALF_DLY:  r_half_dly  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            spimbo_pkg::REG_SPI_MODE:  prdata = {30'd0, r_spi_mode};
            spimbo_pkg::REG_LSB_FIRST: prdata = {31'd0, r_lsb_first};
            spimbo_pkg::REG_HALF_DLY:  prdata = {24'd0, r_half_dly};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // One tick: command decode (idle only), then the clock engine
    // ------------------------------------------------------------------
    always_comb begin
        logic lead;
        spimbo_pkg::t_word rx_word;

        n_activity      = r_activity;
        n_tx_shift      = r_tx_shift;
        n_rx_shift      = r_rx_shift;
        n_bit_index     = r_bit_index;
        n_edge_half     = r_edge_half;
        n_delay_count   = r_delay_count;
        n_clock_level   = r_clock_level;
        n_mosi_level    = r_mosi_level;
        n_select_active = r_select_active;
        n_dummy_left    = r_dummy_left;
        n_rx_out        = 8'd0;
        n_rx_valid      = 1'b0;
        lead            = 1'b0;
        rx_word         = '0;

        if (r_activity == spimbo_pkg::ACT_IDLE) begin
            case (i_action)
                spimbo_pkg::ACTION_BEGIN: begin
                    n_clock_level   = r_spi_mode[1];
                    n_mosi_level    = 1'b1;
                    n_select_active = 1'b1;
                end
                spimbo_pkg::ACTION_XFER: begin
                    n_activity    = spimbo_pkg::ACT_XFER;
                    n_tx_shift    = r_lsb_first ? spimbo_pkg::t_word'(i_tx_byte)
                                  : spimbo_pkg::flip_word(spimbo_pkg::t_word'(i_tx_byte));
                    n_rx_shift    = '0;
                    n_bit_index   = '0;
                    n_edge_half   = 1'b0;
                    n_delay_count = 8'd0;
                end
                spimbo_pkg::ACTION_END: begin
                    n_select_active = 1'b0;
                end
                spimbo_pkg::ACTION_DUMMY: begin
                    if (i_dummy_count != 8'd0) begin
                        n_activity    = spimbo_pkg::ACT_DUMMY;
                        n_dummy_left  = i_dummy_count;
                        n_tx_shift    = spimbo_pkg::WORD_ONES;
                        n_rx_shift    = '0;
                        n_bit_index   = '0;
                        n_edge_half   = 1'b0;
                        n_delay_count = 8'd0;
                    end
                end
                default: ;
            endcase
        end

        if (n_activity != spimbo_pkg::ACT_IDLE) begin
            // first tick of a half: toggle the clock, shift out / sample
            if (n_delay_count == 8'd0) begin
                lead          = !n_edge_half;
                n_clock_level = !n_clock_level;
                if (lead) begin
                    n_mosi_level = n_tx_shift[0];
                    n_tx_shift   = n_tx_shift >> 1;
                end
                if (lead == !r_spi_mode[0]) begin
                    n_rx_shift = {n_rx_shift[spimbo_pkg::BITS_PER_WORD-2:0], i_miso};
                end
            end
            if (n_delay_count >= r_half_dly) begin
                n_delay_count = 8'd0;
                if (!n_edge_half) begin
                    n_edge_half = 1'b1;
                end else begin
                    n_edge_half = 1'b0;
                    n_bit_index = n_bit_index + spimbo_pkg::t_bit_idx'(1);
                    if (n_bit_index == spimbo_pkg::t_bit_idx'(spimbo_pkg::BITS_PER_WORD)) begin
                        if (n_activity == spimbo_pkg::ACT_XFER) begin
                            rx_word    = r_lsb_first ? spimbo_pkg::flip_word(n_rx_shift)
                                                     : n_rx_shift;
                            n_rx_out   = 8'(rx_word);
                            n_rx_valid = 1'b1;
                            n_activity = spimbo_pkg::ACT_IDLE;
                        end else begin
                            n_dummy_left = n_dummy_left - 8'd1;
                            if (n_dummy_left == 8'd0) begin
                                n_activity = spimbo_pkg::ACT_IDLE;
                            end else begin
                                n_tx_shift  = spimbo_pkg::WORD_ONES;
                                n_rx_shift  = '0;
                                n_bit_index = '0;
                            end
                        end
                    end
                end
            end else begin
                n_delay_count = n_delay_count + 8'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // State and output registers, advanced once per accepted beat
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_activity      <= spimbo_pkg::ACT_IDLE;
            r_tx_shift      <= '0;
            r_rx_shift      <= '0;
            r_bit_index     <= '0;
            r_edge_half     <= 1'b0;
            r_delay_count   <= 8'd0;
            r_clock_level   <= 1'b0;
            r_mosi_level    <= 1'b1;
            r_select_active <= 1'b0;
            r_dummy_left    <= 8'd0;
        end else if (w_in_acc) begin
            r_activity      <= n_activity;
            r_tx_shift      <= n_tx_shift;
            r_rx_shift      <= n_rx_shift;
            r_bit_index     <= n_bit_index;
            r_edge_half     <= n_edge_half;
            r_delay_count   <= n_delay_count;
            r_clock_level   <= n_clock_level;
            r_mosi_level    <= n_mosi_level;
            r_select_active <= n_select_active;
            r_dummy_left    <= n_dummy_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload; no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sclk     <= n_clock_level;
            r_mosi     <= n_mosi_level;
            r_cs_n     <= !n_select_active;
            r_rx_byte  <= n_rx_out;
            r_rx_valid <= n_rx_valid;
            r_busy     <= (n_activity != spimbo_pkg::ACT_IDLE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sclk      = r_sclk;
    assign o_mosi      = r_mosi;
    assign o_cs_n      = r_cs_n;
    assign o_rx_byte   = r_rx_byte;
    assign o_rx_valid  = r_rx_valid;
    assign o_busy_res  = r_busy;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rx_valid) |-> !r_busy)
        else $error("rx_valid reported while still busy");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_activity == spimbo_pkg::ACT_IDLE) |-> (!r_edge_half && r_delay_count == 8'd0))
        else $error("idle engine left mid-half");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_activity != spimbo_pkg::ACT_IDLE)
            |-> (r_bit_index < spimbo_pkg::t_bit_idx'(spimbo_pkg::BITS_PER_WORD)))
        else $error("bit index past word end while active");

endmodule

### verif/tb_spi_master_mode_bitorder_unit.sv
`timescale 1ns / 1ps

module tb_spi_master_mode_bitorder_unit;

    // Line levels and flags that one tick produces.
    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              cs_n;
        spimbo_pkg::t_word rx_byte;
        logic              rx_valid;
        logic              busy;
    } t_line_state;

    localparam int N_ITEMS = 1150;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // APB side
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [spimbo_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    // tick beats in
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_action;
    logic [7:0] i_tx_byte;
    logic [7:0] i_dummy_count;
    logic       i_miso;

    // result beats out
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_sclk;
    logic       o_mosi;
    logic       o_cs_n;
    logic [7:0] o_rx_byte;
    logic       o_rx_valid;
    logic       o_busy_res;

    spi_master_mode_bitorder_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_tx_byte     (i_tx_byte),
        .i_dummy_count (i_dummy_count),
        .i_miso        (i_miso),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sclk        (o_sclk),
        .o_mosi        (o_mosi),
        .o_cs_n        (o_cs_n),
        .o_rx_byte     (o_rx_byte),
        .o_rx_valid    (o_rx_valid),
        .o_busy_res    (o_busy_res)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model state: configuration copy plus the shifter and line levels.
    // ------------------------------------------------------------------
    logic [1:0] cfg_mode  = 2'd0;    // bit0 CPHA, bit1 CPOL
    logic       cfg_lsb   = 1'b0;
    logic [7:0] cfg_delay = 8'd0;

    logic [1:0]        activity      = spimbo_pkg::ACT_IDLE;
    spimbo_pkg::t_word shift_out     = '0;
    spimbo_pkg::t_word shift_in      = '0;
    int unsigned       bits_done     = 0;
    logic              trailing_half = 1'b0;
    logic [7:0]        half_ticks    = 8'd0;
    logic              line_sclk     = 1'b0;
    logic              line_mosi     = 1'b1;
    logic              selected      = 1'b0;
    logic [7:0]        dummy_left    = 8'd0;

    t_line_state expected_lines[$];
    t_line_state due_lines;
    int          mismatches = 0;
    int          beats_sent = 0;
    bit          idle_en    = 1'b1;   // random gaps on both sides

    // Arm the shifter for a new word; send order is latched here.
    function automatic void load_word(input spimbo_pkg::t_word w);
        if (cfg_lsb) shift_out = w;
        else shift_out = {<<{w}};
        shift_in      = '0;
        bits_done     = 0;
        trailing_half = 1'b0;
        half_ticks    = 8'd0;
    endfunction

    // One tick of the master: apply the command if idle, then clock the word.
    function automatic t_line_state advance_spi_tick(input logic [2:0] action,
                                                     input spimbo_pkg::t_word tx,
                                                     input logic [7:0] count,
                                                     input logic miso);
        t_line_state       r;
        logic              lead;
        spimbo_pkg::t_word rx_word;
        r = '0;
        if (activity == spimbo_pkg::ACT_IDLE) begin
            case (action)
                spimbo_pkg::ACTION_BEGIN: begin
                    line_sclk = cfg_mode[1];
                    line_mosi = 1'b1;
                    selected  = 1'b1;
                end
                spimbo_pkg::ACTION_XFER: begin
                    activity = spimbo_pkg::ACT_XFER;
                    load_word(tx);
                end
                spimbo_pkg::ACTION_END: selected = 1'b0;
                spimbo_pkg::ACTION_DUMMY: begin
                    if (count != 8'd0) begin
                        activity   = spimbo_pkg::ACT_DUMMY;
                        dummy_left = count;
                        load_word(spimbo_pkg::WORD_ONES);
                    end
                end
                default: ;
            endcase
        end
        if (activity != spimbo_pkg::ACT_IDLE) begin
            // first tick of a half: toggle, shift out on leading, sample per CPHA
            if (half_ticks == 8'd0) begin
                lead      = !trailing_half;
                line_sclk = !line_sclk;
                if (lead) begin
                    line_mosi = shift_out[0];
                    shift_out = shift_out >> 1;
                end
                if (lead == !cfg_mode[0]) begin
                    shift_in = {shift_in[spimbo_pkg::BITS_PER_WORD-2:0], miso};
                end
            end
            if (half_ticks >= cfg_delay) begin
                half_ticks = 8'd0;
                if (!trailing_half) begin
                    trailing_half = 1'b1;
                end else begin
                    trailing_half = 1'b0;
                    bits_done++;
                    if (bits_done >= spimbo_pkg::BITS_PER_WORD) begin
                        if (activity == spimbo_pkg::ACT_XFER) begin
                            // receive order is applied at the end of the word
                            if (cfg_lsb) rx_word = {<<{shift_in}};
                            else rx_word = shift_in;
                            r.rx_byte  = rx_word;
                            r.rx_valid = 1'b1;
                            activity   = spimbo_pkg::ACT_IDLE;
                        end else begin
                            dummy_left = dummy_left - 8'd1;
                            if (dummy_left == 8'd0) activity = spimbo_pkg::ACT_IDLE;
                            else load_word(spimbo_pkg::WORD_ONES);
                        end
                    end
                end
            end else begin
                half_ticks++;
            end
        end
        r.sclk = line_sclk;
        r.mosi = line_mosi;
        r.cs_n = !selected;
        r.busy = (activity != spimbo_pkg::ACT_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat driver: drive on the falling edge, accept on the rising edge.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [2:0] action, input spimbo_pkg::t_word tx,
                             input logic [7:0] count, input logic miso);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= action;
        i_tx_byte     <= tx;
        i_dummy_count <= count;
        i_miso        <= miso;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_lines.push_back(advance_spi_tick(action, tx, count, miso));
        beats_sent++;
    endtask

    // Plain ticks until the model goes idle; noisy mode mixes in commands
    // that the busy master must ignore.
    task automatic run_to_idle(input bit noisy);
        logic [2:0] action;
        while (activity != spimbo_pkg::ACT_IDLE) begin
            action = spimbo_pkg::ACTION_TICK;
            if (noisy && $urandom_range(0, 99) < 12) action = 3'($urandom_range(1, 7));
            send_beat(action, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Issue one command and clock it to completion.
    task automatic send_cmd(input logic [2:0] action, input spimbo_pkg::t_word tx,
                            input logic [7:0] count);
        send_beat(action, tx, count, 1'($urandom_range(0, 1)));
        run_to_idle(1'b0);
    endtask

    // Drop valid and hold off until every pending result beat is back.
    task automatic pause_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            spimbo_pkg::REG_SPI_MODE:  cfg_mode  = value[1:0];
            spimbo_pkg::REG_LSB_FIRST: cfg_lsb   = value[0];
            spimbo_pkg::REG_HALF_DLY:  cfg_delay = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Registers only change with the master idle and nothing in flight.
    task automatic set_config(input logic [1:0] mode, input logic lsb,
                              input logic [7:0] delay);
        run_to_idle(1'b0);
        pause_for_results();
        write_reg(spimbo_pkg::REG_SPI_MODE, {30'd0, mode});
        write_reg(spimbo_pkg::REG_LSB_FIRST, {31'd0, lsb});
        write_reg(spimbo_pkg::REG_HALF_DLY, {24'd0, delay});
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config: every command, undefined codes, edge cases, busy commands.
    task automatic test_commands();
        send_cmd(spimbo_pkg::ACTION_TICK, 8'h00, 8'h00);
        for (int c = int'(spimbo_pkg::ACTION_DUMMY) + 1; c < 8; c++) begin
            send_cmd(3'(c), 8'hFF, 8'hFF);   // undefined codes act as a plain tick
        end
        send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);     // end with nothing open
        send_cmd(spimbo_pkg::ACTION_DUMMY, 8'h00, 8'h00);   // zero dummy bytes: stays idle
        send_cmd(spimbo_pkg::ACTION_XFER, 8'h00, 8'h00);    // transfer with cs_n still high
        send_cmd(spimbo_pkg::ACTION_BEGIN, 8'h00, 8'h00);
        send_cmd(spimbo_pkg::ACTION_XFER, 8'hFF, 8'h00);    // read
        // commands landing mid-word are dropped
        send_beat(spimbo_pkg::ACTION_XFER, 8'h81, 8'h00, 1'b1);
        send_beat(spimbo_pkg::ACTION_BEGIN, 8'h00, 8'h00, 1'b0);
        send_beat(spimbo_pkg::ACTION_END, 8'h00, 8'h00, 1'b1);
        send_beat(spimbo_pkg::ACTION_XFER, 8'h3C, 8'h00, 1'b0);
        send_beat(spimbo_pkg::ACTION_DUMMY, 8'h00, 8'hFF, 1'b1);
        run_to_idle(1'b0);
        send_cmd(spimbo_pkg::ACTION_DUMMY, 8'h00, 8'h01);
        send_cmd(spimbo_pkg::ACTION_DUMMY, 8'h00, 8'h02);
        send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);
    endtask

    // All four modes in both bit orders, then a long half period.
    task automatic test_mode_sweep();
        for (int m = 0; m < 4; m++) begin
            for (int l = 0; l < 2; l++) begin
                set_config(2'(m), 1'(l), 8'd0);
                send_cmd(spimbo_pkg::ACTION_BEGIN, 8'h00, 8'h00);
                send_cmd(spimbo_pkg::ACTION_XFER, 8'($urandom_range(0, 255)), 8'h00);
                send_cmd(spimbo_pkg::ACTION_DUMMY, 8'h00, 8'h01);
                send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);
            end
        end
        set_config(2'd3, 1'b1, 8'd15);
        send_cmd(spimbo_pkg::ACTION_BEGIN, 8'h00, 8'h00);
        send_cmd(spimbo_pkg::ACTION_XFER, 8'hA5, 8'h00);
        send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);
        set_config(2'd0, 1'b0, 8'd0);
    endtask

    // No gaps on either side: one beat per clock the whole way.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 8'd0);
        send_cmd(spimbo_pkg::ACTION_BEGIN, 8'h00, 8'h00);
        repeat (6) send_cmd(spimbo_pkg::ACTION_XFER, 8'($urandom_range(0, 255)), 8'h00);
        send_cmd(spimbo_pkg::ACTION_DUMMY, 8'h00, 8'h03);
        send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);
        idle_en = 1'b1;
    endtask

    // Sender stalls mid-word until the result side has fully caught up.
    task automatic test_pause_mid_word();
        set_config(2'd1, 1'b0, 8'd2);
        send_cmd(spimbo_pkg::ACTION_BEGIN, 8'h00, 8'h00);
        send_beat(spimbo_pkg::ACTION_XFER, 8'($urandom_range(0, 255)), 8'h00,
                  1'($urandom_range(0, 1)));
        repeat (10) send_beat(spimbo_pkg::ACTION_TICK, 8'h00, 8'h00, 1'($urandom_range(0, 1)));
        pause_for_results();
        run_to_idle(1'b0);
        send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);
    endtask

    // Mostly well-formed transactions with random content, some raw noise.
    task automatic test_random_traffic();
        int         pick;
        logic [2:0] action;
        logic [7:0] delay;
        while (beats_sent < N_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) delay = 8'($urandom_range(0, 1));
                else if (pick < 19) delay = 8'($urandom_range(2, 6));
                else delay = 8'($urandom_range(7, 12));
                set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), delay);
            end
            if ($urandom_range(0, 9) < 8) begin
                send_cmd(spimbo_pkg::ACTION_BEGIN, 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 4)) begin
                    send_beat(spimbo_pkg::ACTION_XFER,
                              ($urandom_range(0, 3) == 0) ? 8'hFF
                                                          : 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    run_to_idle(1'b1);
                end
                if ($urandom_range(0, 9) < 3) begin
                    send_beat(spimbo_pkg::ACTION_DUMMY, 8'($urandom_range(0, 255)),
                              8'($urandom_range(1, 2)), 1'($urandom_range(0, 1)));
                    run_to_idle(1'b1);
                end
                if ($urandom_range(0, 9) < 8) begin
                    send_cmd(spimbo_pkg::ACTION_END, 8'h00, 8'h00);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    action = 3'($urandom_range(0, 7));
                    send_beat(action, 8'($urandom_range(0, 255)),
                              (action == spimbo_pkg::ACTION_DUMMY)
                                  ? 8'($urandom_range(0, 3))
                                  : 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end
                run_to_idle(1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, in-order compare.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_ready <= idle_en ? ($urandom_range(0, 99) >= 26) : 1'b1;
    end

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got);
        if (got !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_lines.size() == 0) begin
                mismatches++;
                $display("%0t: result beat with nothing expected", $time);
            end else begin
                due_lines = expected_lines.pop_front();
                check_field("sclk", 8'(due_lines.sclk), 8'(o_sclk));
                check_field("mosi", 8'(due_lines.mosi), 8'(o_mosi));
                check_field("cs_n", 8'(due_lines.cs_n), 8'(o_cs_n));
                check_field("rx_byte", 8'(due_lines.rx_byte), o_rx_byte);
                check_field("rx_valid", 8'(due_lines.rx_valid), 8'(o_rx_valid));
                check_field("busy", 8'(due_lines.busy), 8'(o_busy_res));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_action      = spimbo_pkg::ACTION_TICK;
        i_tx_byte     = '0;
        i_dummy_count = '0;
        i_miso        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_mode_sweep();
        test_back_to_back();
        test_pause_mid_word();
        test_random_traffic();

        run_to_idle(1'b0);
        pause_for_results();
        repeat (8) @(posedge i_clk);   // a little slack

        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("PASS spi_master_mode_bitorder_unit");
        end else begin
            $display("FAIL spi_master_mode_bitorder_unit");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("FAIL spi_master_mode_bitorder_unit");
        $finish;
    end

endmodule

### filelist.f
rtl/core/spimbo_pkg.sv
rtl/core/spi_master_mode_bitorder_unit.sv
verif/tb_spi_master_mode_bitorder_unit.sv
